/* sv/enn_pkg.sv */
// Shared types and constants for the nearest-neighbor search block.
// Field widths, register map, request codes and the search tag struct.
// No dependencies.
package enn_pkg;

   localparam int MAX_TRAIN_DEFAULT = 256;
   localparam int MAX_DIMS_DEFAULT  = 64;

   localparam int COORD_W     = 16;
   localparam int SLOT_FIELD_W = 8;
   localparam int DIM_FIELD_W = 6;
   localparam int REF_COUNT_W = 9;
   localparam int DIM_COUNT_W = 7;
   localparam int DIST_W      = 38;
   localparam int SQUARE_W    = 32;

   localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index is taken from the word address bit.
   localparam logic CSR_IDX_REF_COUNT = 1'b0;
   localparam logic CSR_IDX_DIM_COUNT = 1'b1;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Control that travels with each coordinate pair through the datapath.
   typedef struct packed {
      logic valid;
      logic first_dim;
      logic last_dim;
      logic last_ref;
   } srch_tag_type;

endpackage

/* sv/enn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds reference coordinates and the query vector. No dependencies.
module enn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/enn_dist_unit.sv */
// Shared distance unit: difference, square, running sum and best-match tracking.
// One coordinate pair per cycle, two pipeline stages. Depends on enn_pkg.
module enn_dist_unit
   import enn_pkg::*;
#(
   parameter int SLOT_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  srch_tag_type              tag,
   input  logic [SLOT_W-1:0]         slot,
   input  logic [COORD_W-1:0]        query_coord,
   input  logic [COORD_W-1:0]        ref_coord,
   output logic [SLOT_W-1:0]         best_slot,
   output logic [DIST_W-1:0]         best_dist,
   output logic                      found,
   output logic                      done
);

   srch_tag_type          tag_a_ff;
   logic [SLOT_W-1:0]     slot_a_ff;
   logic [SQUARE_W-1:0]   sq_ff;
   logic [SQUARE_W-1:0]   sq_in;
   logic [DIST_W-1:0]     acc_ff;
   logic [DIST_W-1:0]     acc_in;
   logic [DIST_W-1:0]     best_dist_ff;
   logic [SLOT_W-1:0]     best_slot_ff;
   logic                  found_ff;
   logic                  done_ff;
   logic signed [COORD_W:0] diff;
   logic [COORD_W-1:0]    mag;
   logic [DIST_W:0]       sum_wide;

   // Stage A: absolute difference and square.
   always_comb begin
      diff  = $signed({query_coord[COORD_W-1], query_coord}) -
              $signed({ref_coord[COORD_W-1], ref_coord});
      mag   = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);
      sq_in = SQUARE_W'(mag) * SQUARE_W'(mag);
   end

   // Stage B: saturating accumulate, restart on the first dimension.
   always_comb begin
      sum_wide = {1'b0, acc_ff} + (DIST_W + 1)'(sq_ff);
      if (tag_a_ff.first_dim) begin
         acc_in = DIST_W'(sq_ff);
      end else if (sum_wide[DIST_W]) begin
         acc_in = DIST_ALL_ONES;
      end else begin
         acc_in = sum_wide[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         found_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         tag_a_ff <= tag;
         done_ff  <= tag_a_ff.valid && tag_a_ff.last_ref;
         if (clear) begin
            found_ff <= 1'b0;
         end else if (tag_a_ff.valid && tag_a_ff.last_dim &&
                      (!found_ff || acc_in < best_dist_ff)) begin
            found_ff <= 1'b1;
         end
      end
      slot_a_ff <= slot;
      sq_ff     <= sq_in;
      if (tag_a_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (clear) begin
         best_dist_ff <= DIST_ALL_ONES;
         best_slot_ff <= '0;
      end else if (tag_a_ff.valid && tag_a_ff.last_dim &&
                   (!found_ff || acc_in < best_dist_ff)) begin
         // strict compare keeps the earlier slot on a tie
         best_dist_ff <= acc_in;
         best_slot_ff <= slot_a_ff;
      end
   end

   assign best_slot = best_slot_ff;
   assign best_dist = best_dist_ff;
   assign found     = found_ff;
   assign done      = done_ff;

endmodule

/* sv/euclidean_nearest_neighbor_top.sv */
// Nearest-neighbor search by squared Euclidean distance over stored references.
// Load and non-final query requests are accepted one per cycle while the block is idle.
// A final query request walks refs * dims coordinate pairs, one per cycle, through the
// shared distance unit, or skips to the finish state with no references. Requests wait
// until its result is registered or while an older result waits. Reset initializes
// control and CSRs, not datapath registers or memories. Uses enn_pkg, enn_ram, enn_dist_unit.
module euclidean_nearest_neighbor_top
   import enn_pkg::*;
#(
   parameter int MAX_TRAIN = MAX_TRAIN_DEFAULT,
   parameter int MAX_DIMS  = MAX_DIMS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_action,
   input  logic [SLOT_FIELD_W-1:0]  req_reference_slot,
   input  logic [DIM_FIELD_W-1:0]   req_dimension,
   input  logic signed [COORD_W-1:0] req_coordinate,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [SLOT_FIELD_W-1:0]  rsp_nearest_slot,
   output logic [DIST_W-1:0]        rsp_least_distance,
   output logic                     rsp_found,
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   localparam int SLOT_W  = $clog2(MAX_TRAIN);
   localparam int DIM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CNT_W   = ($clog2(MAX_TRAIN + 1) > REF_COUNT_W) ?
                            $clog2(MAX_TRAIN + 1) : REF_COUNT_W;
   localparam int DCNT_W  = ($clog2(MAX_DIMS + 1) > DIM_COUNT_W) ?
                            $clog2(MAX_DIMS + 1) : DIM_COUNT_W;
   localparam int REF_DEPTH = MAX_TRAIN * (2 ** DIM_W);
   localparam int QRY_DEPTH = 2 ** DIM_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [SLOT_W-1:0]         r_ff, r_in;
   logic [DIM_W-1:0]          i_ff, i_in;
   srch_tag_type              issue_tag_ff, issue_tag_in;
   logic [SLOT_W-1:0]         issue_slot_ff, issue_slot_in;
   logic [REF_COUNT_W-1:0]    ref_count_ff;
   logic [DIM_COUNT_W-1:0]    dim_count_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SLOT_FIELD_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [DIST_W-1:0]         rsp_dist_ff, rsp_dist_in;
   logic                      rsp_found_ff, rsp_found_in;

   logic                      req_accept;
   logic                      csr_write;
   logic [CNT_W-1:0]          ref_count_ext;
   logic [CNT_W-1:0]          eff_refs;
   logic [DCNT_W-1:0]         dim_count_ext;
   logic [DCNT_W-1:0]         eff_dims;
   logic [DCNT_W-1:0]         dim_ext;
   logic                      dim_ok;
   logic                      slot_ok;
   logic                      ref_we;
   logic                      qry_we;
   logic                      search_start;
   logic [SLOT_W-1:0]         last_slot;
   logic [DIM_W-1:0]          last_dim;
   logic                      issue_last_dim;
   logic                      issue_last_ref;
   logic                      out_free;
   logic [COORD_W-1:0]        ref_rd_data;
   logic [COORD_W-1:0]        qry_rd_data;
   logic [SLOT_W-1:0]         best_slot;
   logic [DIST_W-1:0]         best_dist;
   logic                      best_found;
   logic                      dist_done;

   // Effective counts after clamping.
   always_comb begin
      ref_count_ext = CNT_W'(ref_count_ff);
      eff_refs      = (ref_count_ext > CNT_W'(MAX_TRAIN)) ? CNT_W'(MAX_TRAIN) : ref_count_ext;
      dim_count_ext = DCNT_W'(dim_count_ff);
      if (dim_count_ff == '0) begin
         eff_dims = DCNT_W'(1);
      end else if (dim_count_ext > DCNT_W'(MAX_DIMS)) begin
         eff_dims = DCNT_W'(MAX_DIMS);
      end else begin
         eff_dims = dim_count_ext;
      end
      last_slot = SLOT_W'(eff_refs - CNT_W'(1));
      last_dim  = DIM_W'(eff_dims - DCNT_W'(1));
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign dim_ext    = DCNT_W'(req_dimension);
   assign dim_ok     = dim_ext < eff_dims;
   assign slot_ok    = CNT_W'(req_reference_slot) < CNT_W'(MAX_TRAIN);
   assign ref_we     = req_accept && (req_action == ACT_LOAD) && dim_ok && slot_ok;
   assign qry_we     = req_accept && (req_action == ACT_QUERY) && dim_ok;
   assign search_start = qry_we && (dim_ext == eff_dims - DCNT_W'(1));
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign issue_last_dim = (i_ff == last_dim);
   assign issue_last_ref = issue_last_dim && (r_ff == last_slot);

   // Sequencer: walk every active reference coordinate, one per cycle, then post the result.
   always_comb begin
      state_in      = state_ff;
      r_in          = r_ff;
      i_in          = i_ff;
      issue_tag_in  = '0;
      issue_slot_in = r_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_found_in  = rsp_found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (search_start) begin
               r_in     = '0;
               i_in     = '0;
               state_in = (eff_refs == '0) ? ST_FINISH : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            issue_tag_in.valid     = 1'b1;
            issue_tag_in.first_dim = (i_ff == '0);
            issue_tag_in.last_dim  = issue_last_dim;
            issue_tag_in.last_ref  = issue_last_ref;
            if (issue_last_dim) begin
               i_in = '0;
               r_in = r_ff + SLOT_W'(1);
               if (issue_last_ref) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               i_in = i_ff + DIM_W'(1);
            end
         end
         ST_DRAIN: begin
            if (dist_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = SLOT_FIELD_W'(best_slot);
               rsp_dist_in  = best_dist;
               rsp_found_in = best_found;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_tag_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ref_count_ff <= '0;
         dim_count_ff <= DIM_COUNT_W'(1);
      end else begin
         state_ff     <= state_in;
         issue_tag_ff <= issue_tag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && (csr_paddr[2] == CSR_IDX_REF_COUNT)) begin
            ref_count_ff <= csr_pwdata[REF_COUNT_W-1:0];
         end
         if (csr_write && (csr_paddr[2] == CSR_IDX_DIM_COUNT)) begin
            dim_count_ff <= csr_pwdata[DIM_COUNT_W-1:0];
         end
      end
      r_ff          <= r_in;
      i_ff          <= i_in;
      issue_slot_ff <= issue_slot_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_found_ff  <= rsp_found_in;
   end

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_DIM_COUNT) ? CSR_DATA_W'(dim_count_ff)
                                                            : CSR_DATA_W'(ref_count_ff);

   enn_ram #(
      .WIDTH (COORD_W),
      .DEPTH (REF_DEPTH)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr ({SLOT_W'(req_reference_slot), DIM_W'(req_dimension)}),
      .wr_data (req_coordinate),
      .rd_addr ({r_ff, i_ff}),
      .rd_data (ref_rd_data)
   );

   enn_ram #(
      .WIDTH (COORD_W),
      .DEPTH (QRY_DEPTH)
   ) u_qry_ram (
      .clock   (clock),
      .wr_en   (qry_we),
      .wr_addr (DIM_W'(req_dimension)),
      .wr_data (req_coordinate),
      .rd_addr (i_ff),
      .rd_data (qry_rd_data)
   );

   enn_dist_unit #(
      .SLOT_W (SLOT_W)
   ) u_dist (
      .clock       (clock),
      .reset       (reset),
      .clear       (search_start),
      .tag         (issue_tag_ff),
      .slot        (issue_slot_ff),
      .query_coord (qry_rd_data),
      .ref_coord   (ref_rd_data),
      .best_slot   (best_slot),
      .best_dist   (best_dist),
      .found       (best_found),
      .done        (dist_done)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_nearest_slot   = rsp_slot_ff;
   assign rsp_least_distance = rsp_dist_ff;
   assign rsp_found          = rsp_found_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish state");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      dist_done |-> state_ff == ST_DRAIN)
      else $error("distance unit finished outside drain state");

   a_last_ref_tag: assert property (@(posedge clock) disable iff (reset)
      issue_tag_ff.last_ref |-> issue_tag_ff.valid && issue_tag_ff.last_dim)
      else $error("last reference tag without last dimension");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |->
         rsp_dist_ff == DIST_ALL_ONES && rsp_slot_ff == '0)
      else $error("empty search result not in its fixed form");

endmodule
